// File: hdl/mva_pkg.sv
package mva_pkg;

    localparam int CHANNELS = 16;
    localparam int VOICES   = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int VI_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LINK_W   = $clog2(VOICES + 1);
    localparam int SCAN_W   = $clog2(VOICES + 1);
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(VOICES);

    localparam logic [2:0] OP_NOTE_ON  = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF = 3'd1;
    localparam logic [2:0] OP_CTRL     = 3'd2;
    localparam logic [2:0] OP_PROG     = 3'd3;
    localparam logic [2:0] OP_BEND     = 3'd4;

    localparam logic [2:0] OC_SENT     = 3'd0;
    localparam logic [2:0] OC_STORED   = 3'd1;
    localparam logic [2:0] OC_IGNORED  = 3'd2;
    localparam logic [2:0] OC_NO_VOICE = 3'd3;
    localparam logic [2:0] OC_NO_MATCH = 3'd4;

    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hb;
    localparam logic [3:0] ST_PROG     = 4'hc;
    localparam logic [3:0] ST_BEND     = 4'he;

    localparam logic [6:0] CC_ALLOW = 7'd17;
    localparam logic [6:0] CC_PRIO  = 7'd18;

    // one voice table entry
    typedef struct packed {
        logic [3:0]        chan;
        logic [6:0]        note;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } voice_t;

    // one result beat
    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_first;
        logic [6:0] data_second;
        logic [1:0] byte_count;
        logic [2:0] outcome;
        logic       last;
    } res_t;

    function automatic logic [6:0] scale_vel(input logic [6:0] v);
        logic [13:0] p;
        begin
            p = 14'd110 * {7'd0, v};
            scale_vel = 7'(p >> 7) + 7'd17;
        end
    endfunction

endpackage

// File: hdl/mva_voice_ram.sv
module mva_voice_ram (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [mva_pkg::VI_W-1:0] waddr,
    input  mva_pkg::voice_t       wdata,
    input  logic [mva_pkg::VI_W-1:0] raddr,
    output mva_pkg::voice_t       rdata
);
    import mva_pkg::*;

    voice_t mem [VOICES];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/midi_voice_allocator.sv
// MIDI voice allocator.
// Input channel s_*: one event per beat (op, channel, key, value, bend).
// Result channel m_*: one or two result beats per event; m_last marks
// the final beat. Unknown ops and out-of-range channels give no beat.
// Events are handled one at a time; s_ready is high only while idle.
// A simple event is decoded and its beat emitted; a note-on with a free
// voice first pops the free list and pushes the voice on the active list.
// Note-off and voice steal walk the active list through the voice table;
// the walk length and the list relinking set their duration.
// After reset a clearing pass builds the free chain in the voice table;
// no event is accepted during it.
// Each result beat sits in an output register; when the receiver stalls
// the sequencer waits on that beat and s_ready stays low.
module midi_voice_allocator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [3:0] s_channel,
    input  logic [6:0] s_key,
    input  logic [6:0] s_value,
    input  logic [13:0] s_bend,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_status_byte,
    output logic [6:0] m_data_first,
    output logic [6:0] m_data_second,
    output logic [1:0] m_byte_count,
    output logic [2:0] m_outcome,
    output logic       m_last
);
    import mva_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DEC    = 5'd2;
    localparam logic [4:0] S_FRD    = 5'd3;  // read free head
    localparam logic [4:0] S_FWT    = 5'd4;
    localparam logic [4:0] S_FNX    = 5'd5;  // fix next's prev
    localparam logic [4:0] S_SCRD   = 5'd6;  // scan read
    localparam logic [4:0] S_SCWT   = 5'd7;
    localparam logic [4:0] S_SCEV   = 5'd8;
    localparam logic [4:0] S_ULRD   = 5'd9;  // unlink victim read
    localparam logic [4:0] S_ULWT   = 5'd10;
    localparam logic [4:0] S_ULP    = 5'd11;
    localparam logic [4:0] S_ULN    = 5'd12;
    localparam logic [4:0] S_EMOFF  = 5'd13;
    localparam logic [4:0] S_PUSH   = 5'd14; // write v into active list
    localparam logic [4:0] S_PUSHH  = 5'd15; // fix old head prev
    localparam logic [4:0] S_EMIT   = 5'd16;
    localparam logic [4:0] S_WAIT   = 5'd17;
    localparam logic [4:0] S_FPUSH  = 5'd18; // free push
    localparam logic [4:0] S_FPUSHH = 5'd19;
    localparam logic [4:0] S_ULX    = 5'd20; // fix next's prev on unlink

    logic [4:0] state_reg, state_next;

    // event
    logic [2:0]  op_reg;
    logic [3:0]  ch_reg;
    logic [6:0]  key_reg, val_reg;
    logic [13:0] bend_reg;

    // list heads
    logic [LINK_W-1:0] ahead_reg, fhead_reg;

    // channel tables in flip-flops
    logic [4:0] cnt_reg [CHANNELS];
    logic       ovf_reg [CHANNELS];
    logic [6:0] pri_reg [CHANNELS];
    logic [6:0] alw_reg [CHANNELS];

    // walk
    logic [LINK_W-1:0] cur_reg;
    logic [SCAN_W-1:0] steps_reg;
    logic [LINK_W-1:0] sel_reg;
    logic              sov_reg;
    logic [6:0]        spr_reg;
    logic [LINK_W-1:0] v_reg;     // voice being unlinked / taken
    voice_t            ent_reg;   // its entry
    logic [3:0]        vc_reg;
    logic [6:0]        vn_reg;

    // pending beat
    res_t res_reg;
    logic mv_reg;
    logic [4:0] after_reg;

    // RAM
    logic   we;
    logic [VI_W-1:0] waddr, raddr;
    voice_t wdata, rdata;
    logic [VI_W-1:0] init_reg;

    mva_voice_ram u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = mv_reg;
    assign m_status_byte = res_reg.status_byte;
    assign m_data_first  = res_reg.data_first;
    assign m_data_second = res_reg.data_second;
    assign m_byte_count  = res_reg.byte_count;
    assign m_outcome     = res_reg.outcome;
    assign m_last        = res_reg.last;

    function automatic res_t mk(input logic [7:0] st, input logic [6:0] d1,
                                input logic [6:0] d2, input logic [1:0] bc,
                                input logic [2:0] oc, input logic l);
        res_t r;
        begin
            r.status_byte = st; r.data_first = d1; r.data_second = d2;
            r.byte_count = bc; r.outcome = oc; r.last = l;
            mk = r;
        end
    endfunction

    // take decision for the current scanned voice
    logic [CH_W-1:0] rc;
    logic            cov, take;
    logic [6:0]      cpr;
    always_comb begin
        rc   = CH_W'(rdata.chan);
        cov  = ovf_reg[rc];
        cpr  = pri_reg[rc];
        take = (cov == sov_reg) ? (cpr <= spr_reg) : cov;
    end

    logic [CH_W-1:0] chi, vci;
    assign chi = CH_W'(ch_reg);
    assign vci = CH_W'(vc_reg);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            mv_reg    <= 1'b0;
            ahead_reg <= NIL_LINK;
            fhead_reg <= LINK_W'(VOICES - 1);
            for (int i = 0; i < CHANNELS; i++) begin
                cnt_reg[i] <= '0; ovf_reg[i] <= 1'b0;
                pri_reg[i] <= '0; alw_reg[i] <= 7'd1;
            end
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            unique case (state_reg)
                S_INIT: begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == VI_W'(VOICES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg <= s_op; ch_reg <= s_channel; key_reg <= s_key;
                        val_reg <= s_value; bend_reg <= s_bend;
                        state_reg <= (s_op > OP_BEND || 32'(s_channel) >= CHANNELS)
                                     ? S_IDLE : S_DEC;
                    end
                end
                S_DEC: begin
                    after_reg <= S_IDLE;
                    state_reg <= S_EMIT;
                    unique case (op_reg)
                        OP_NOTE_ON: begin
                            if (fhead_reg != NIL_LINK) begin
                                v_reg <= fhead_reg; state_reg <= S_FRD;
                            end else begin
                                cur_reg <= ahead_reg; steps_reg <= '0;
                                sel_reg <= NIL_LINK;
                                sov_reg <= ovf_reg[chi]; spr_reg <= pri_reg[chi];
                                state_reg <= S_SCRD;
                            end
                        end
                        OP_NOTE_OFF: begin
                            cur_reg <= ahead_reg; steps_reg <= '0;
                            state_reg <= S_SCRD;
                        end
                        OP_CTRL: begin
                            if (key_reg == 7'd1 || key_reg == 7'd7 || key_reg == 7'd10
                                || key_reg == 7'd91 || key_reg == 7'd93)
                                res_reg <= mk({ST_CTRL, ch_reg}, key_reg, val_reg,
                                              2'd3, OC_SENT, 1'b1);
                            else if (key_reg == CC_ALLOW) begin
                                alw_reg[chi] <= val_reg;
                                res_reg <= mk(8'd0, 7'd0, 7'd0, 2'd0, OC_STORED, 1'b1);
                            end else if (key_reg == CC_PRIO) begin
                                pri_reg[chi] <= val_reg;
                                res_reg <= mk(8'd0, 7'd0, 7'd0, 2'd0, OC_STORED, 1'b1);
                            end else
                                res_reg <= mk(8'd0, 7'd0, 7'd0, 2'd0, OC_IGNORED, 1'b1);
                        end
                        OP_PROG:
                            res_reg <= mk({ST_PROG, ch_reg}, key_reg, 7'd0, 2'd2,
                                          OC_SENT, 1'b1);
                        default:
                            res_reg <= mk({ST_BEND, ch_reg}, bend_reg[6:0],
                                          bend_reg[13:7], 2'd3, OC_SENT, 1'b1);
                    endcase
                end
                // free voice: read its entry, pop the free list
                S_FRD: state_reg <= S_FWT;
                S_FWT: begin
                    fhead_reg <= rdata.next;
                    state_reg <= (rdata.next != NIL_LINK) ? S_FNX : S_PUSH;
                end
                S_FNX: state_reg <= S_PUSH;
                // list walk
                S_SCRD: begin
                    if (cur_reg == NIL_LINK || 32'(steps_reg) >= VOICES) begin
                        if (op_reg == OP_NOTE_OFF) begin
                            res_reg <= mk(8'd0, 7'd0, 7'd0, 2'd0, OC_NO_MATCH, 1'b1);
                            state_reg <= S_EMIT;
                        end else if (sel_reg == NIL_LINK) begin
                            res_reg <= mk(8'd0, 7'd0, 7'd0, 2'd0, OC_NO_VOICE, 1'b1);
                            state_reg <= S_EMIT;
                        end else begin
                            v_reg <= sel_reg; state_reg <= S_ULRD;
                        end
                    end else
                        state_reg <= S_SCWT;
                end
                S_SCWT: state_reg <= S_SCEV;
                S_SCEV: begin
                    cur_reg <= rdata.next;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_SCRD;
                    if (op_reg == OP_NOTE_OFF) begin
                        if (rdata.chan == ch_reg && rdata.note == key_reg) begin
                            v_reg <= cur_reg; state_reg <= S_ULRD;
                        end
                    end else if (take) begin
                        sel_reg <= cur_reg; sov_reg <= cov; spr_reg <= cpr;
                    end
                end
                // unlink from active list
                S_ULRD: state_reg <= S_ULWT;
                S_ULWT: begin
                    ent_reg <= rdata;
                    vc_reg <= rdata.chan; vn_reg <= rdata.note;
                    if (rdata.prev == NIL_LINK) ahead_reg <= rdata.next;
                    state_reg <= S_ULP;
                end
                S_ULP: state_reg <= S_ULN;
                S_ULN: state_reg <= S_ULX;
                S_ULX: begin
                    // count drop for the freed voice's channel
                    if (cnt_reg[vci] != 5'd0) begin
                        cnt_reg[vci] <= cnt_reg[vci] - 1'b1;
                        ovf_reg[vci] <= {2'd0, cnt_reg[vci] - 1'b1} > alw_reg[vci];
                    end else
                        ovf_reg[vci] <= 1'b0;
                    if (op_reg == OP_NOTE_OFF) begin
                        res_reg <= mk({ST_NOTE_OFF, ch_reg}, key_reg, 7'd64, 2'd3,
                                      OC_SENT, 1'b1);
                        after_reg <= S_FPUSH;
                    end else begin
                        res_reg <= mk({ST_NOTE_OFF, vc_reg}, vn_reg, 7'd64, 2'd3,
                                      OC_SENT, 1'b0);
                        after_reg <= S_PUSH;
                    end
                    state_reg <= S_EMIT;
                end
                // push onto active list
                S_PUSH: begin
                    if (ahead_reg != NIL_LINK)
                        state_reg <= S_PUSHH;
                    else begin
                        ahead_reg <= v_reg;
                        state_reg <= S_EMOFF;
                    end
                end
                S_PUSHH: begin
                    ahead_reg <= v_reg;
                    state_reg <= S_EMOFF;
                end
                S_EMOFF: begin
                    if (cnt_reg[chi] != 5'd31) begin
                        cnt_reg[chi] <= cnt_reg[chi] + 1'b1;
                        ovf_reg[chi] <= {2'd0, cnt_reg[chi] + 1'b1} > alw_reg[chi];
                    end else
                        ovf_reg[chi] <= {2'd0, cnt_reg[chi]} > alw_reg[chi];
                    res_reg <= mk({ST_NOTE_ON, ch_reg}, key_reg, scale_vel(val_reg),
                                  2'd3, OC_SENT, 1'b1);
                    after_reg <= S_IDLE;
                    state_reg <= S_EMIT;
                end
                // push onto free list
                S_FPUSH: begin
                    if (fhead_reg != NIL_LINK)
                        state_reg <= S_FPUSHH;
                    else begin
                        fhead_reg <= v_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_FPUSHH: begin
                    fhead_reg <= v_reg;
                    state_reg <= S_IDLE;
                end
                S_EMIT: begin
                    if (!mv_reg) begin
                        mv_reg <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (m_ready) state_reg <= after_reg;
                end
                default: state_reg <= S_INIT;
            endcase
        end
    end

    // voice table port drive
    logic [LINK_W-1:0] nxt_l;
    always_comb begin
        we    = 1'b0;
        waddr = VI_W'(v_reg);
        wdata = '0;
        raddr = VI_W'(v_reg);
        nxt_l = LINK_W'(init_reg) + 1'b1;
        unique case (state_reg)
            S_INIT: begin
                we = 1'b1; waddr = init_reg;
                wdata.chan = '0; wdata.note = '0;
                wdata.next = (init_reg == '0) ? NIL_LINK : LINK_W'(init_reg) - 1'b1;
                wdata.prev = (32'(init_reg) == VOICES - 1) ? NIL_LINK : nxt_l;
            end
            S_SCRD, S_SCWT: raddr = VI_W'(cur_reg);
            S_FWT: raddr = VI_W'(rdata.next);
            S_FNX: begin
                // new free head loses its prev
                we = 1'b1; waddr = VI_W'(fhead_reg);
                wdata = rdata; wdata.prev = NIL_LINK;
            end
            S_ULP: raddr = VI_W'(ent_reg.prev);
            S_ULN: begin
                // prev entry read now valid: patch its next, read the next entry
                raddr = VI_W'(ent_reg.next);
                if (ent_reg.prev != NIL_LINK) begin
                    we = 1'b1; waddr = VI_W'(ent_reg.prev);
                    wdata = rdata; wdata.next = ent_reg.next;
                end
            end
            S_ULX: begin
                // patch the next entry's prev
                if (ent_reg.next != NIL_LINK) begin
                    we = 1'b1; waddr = VI_W'(ent_reg.next);
                    wdata = rdata; wdata.prev = ent_reg.prev;
                end
            end
            S_PUSH: begin
                we = 1'b1;
                wdata.chan = ch_reg; wdata.note = key_reg;
                wdata.next = ahead_reg; wdata.prev = NIL_LINK;
                raddr = VI_W'(ahead_reg);
            end
            S_PUSHH: begin
                we = 1'b1; waddr = VI_W'(ahead_reg);
                wdata = rdata; wdata.prev = v_reg;
            end
            S_FPUSH: begin
                we = 1'b1;
                wdata.chan = vc_reg; wdata.note = vn_reg;
                wdata.next = fhead_reg; wdata.prev = NIL_LINK;
                raddr = VI_W'(fhead_reg);
            end
            S_FPUSHH: begin
                we = 1'b1; waddr = VI_W'(fhead_reg);
                wdata = rdata; wdata.prev = v_reg;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    // hold a waiting beat until it is taken
    a_mvalid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid);
    // hold the payload of a waiting beat
    a_mpayload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(res_reg));
    // no new event while a beat is out
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready);
    // a beat without a message always ends its event
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_count == 2'd0 |-> m_last);
`endif

endmodule
